### rtl/rmsr_pkg.sv
package rmsr_pkg;

  // Default slot count and the number of slots the registers describe.
  localparam int NUM_SLOTS = 4;
  localparam int REG_SLOTS = 4;

  // Stream widths (payload padded to whole bytes).
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [15:0] STALE_RESET = 16'd500;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLOT_ENABLE      = 2'd0,
    REG_SLOT_SENSOR_ADDR = 2'd1,
    REG_SLOT_RECV_NODE   = 2'd2,
    REG_STALE_TIMEOUT    = 2'd3
  } cfg_reg_t;

  // Reading kind codes on the input side.
  localparam logic [7:0] READ_VALID     = 8'd1;
  localparam logic [7:0] READ_TOO_CLOSE = 8'd2;
  localparam logic [7:0] READ_TOO_FAR   = 8'd3;

  // Sensor kind codes on the input side.
  localparam logic [7:0] KIND_IN_SONAR = 8'd1;
  localparam logic [7:0] KIND_IN_RADAR = 8'd3;

  // Slot status codes.
  localparam logic [1:0] STATUS_NO_DATA = 2'd0;

  typedef struct packed {
    logic [15:0] stale_timeout_ms;
    logic [27:0] slot_recv_node;
    logic [31:0] slot_sensor_addr;
    logic [3:0]  slot_enable;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [1:0]  poll_slot;
    logic [15:0] range_mm;
    logic [7:0]  sensor_kind_in;
    logic [7:0]  reading_kind;
    logic [7:0]  target_id;
    logic [6:0]  source_node;
    logic [1:0]  can_bus;
    logic        mode;
  } item_t;

  typedef struct packed {
    logic [1:0]  sensor_kind;
    logic [15:0] distance_mm;
    logic [1:0]  slot_status;
    logic [1:0]  slot_index;
    logic        matched;
  } result_t;

  // True for the reading kinds that carry a range.
  function automatic logic is_reading(input logic [7:0] rkind);
    is_reading = (rkind >= READ_VALID) && (rkind <= READ_TOO_FAR);
  endfunction

  // Known sensor kinds map to themselves, anything else to unknown.
  function automatic logic [1:0] map_kind(input logic [7:0] skind);
    if ((skind >= KIND_IN_SONAR) && (skind <= KIND_IN_RADAR)) begin
      map_kind = skind[1:0];
    end else begin
      map_kind = 2'd0;
    end
  endfunction

endpackage

### rtl/rmsr_cfg_regs.sv
module rmsr_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rmsr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rmsr_pkg::CFG_DATA_W-1:0]      cfg_data,
  output rmsr_pkg::cfg_t                       cfg
);
  import rmsr_pkg::*;

  // Writes are taken in any cycle.
  assign cfg_ready = 1'b1;

  // Register file, each value masked to its width.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slot_enable      <= '0;
      cfg.slot_sensor_addr <= '0;
      cfg.slot_recv_node   <= '0;
      cfg.stale_timeout_ms <= STALE_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_SLOT_ENABLE:      cfg.slot_enable      <= cfg_data[3:0];
        REG_SLOT_SENSOR_ADDR: cfg.slot_sensor_addr <= cfg_data[31:0];
        REG_SLOT_RECV_NODE:   cfg.slot_recv_node   <= cfg_data[27:0];
        REG_STALE_TIMEOUT:    cfg.stale_timeout_ms <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/rmsr_slot_match.sv
module rmsr_slot_match #(
  parameter int SLOTS = rmsr_pkg::NUM_SLOTS
) (
  input  rmsr_pkg::cfg_t     cfg,
  input  rmsr_pkg::item_t    item,
  input  logic [SLOTS-1:0]   bound_valid,
  input  logic [1:0]         bound_bus [SLOTS],
  input  logic [6:0]         bound_node [SLOTS],
  output logic [SLOTS-1:0]   sel_oh,
  output logic [SLOTS-1:0]   release_oh,
  output logic [1:0]         sel_idx
);
  import rmsr_pkg::*;

  logic [SLOTS-1:0] cfg_hit;
  logic [SLOTS-1:0] bnd_hit;
  logic [SLOTS-1:0] unb_hit;
  logic [SLOTS-1:0] cfg_oh;
  logic [SLOTS-1:0] bnd_oh;
  logic [SLOTS-1:0] unb_oh;

  // Classify every slot; slots past the register range are never enabled.
  for (genvar g = 0; g < SLOTS; g++) begin : g_slot
    if (g < REG_SLOTS) begin : g_live
      logic       cand;
      logic [6:0] rv;
      assign cand = cfg.slot_enable[g] &&
                    (cfg.slot_sensor_addr[8*g +: 8] == item.target_id);
      assign rv   = cfg.slot_recv_node[7*g +: 7];
      assign cfg_hit[g] = cand && (rv != 7'd0) && (rv == item.source_node);
      assign unb_hit[g] = cand && (rv == 7'd0) && !bound_valid[g];
      assign bnd_hit[g] = cand && (rv == 7'd0) && bound_valid[g] &&
                          (bound_bus[g] == item.can_bus) &&
                          (bound_node[g] == item.source_node);
    end else begin : g_dead
      assign cfg_hit[g] = 1'b0;
      assign unb_hit[g] = 1'b0;
      assign bnd_hit[g] = 1'b0;
    end
  end

  // Lowest configured and unbound candidates, highest bound candidate.
  assign cfg_oh = cfg_hit & (~cfg_hit + SLOTS'(1));
  assign unb_oh = unb_hit & (~unb_hit + SLOTS'(1));

  always_comb begin
    logic found;
    found  = 1'b0;
    bnd_oh = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (bnd_hit[i] && !found) begin
        bnd_oh[i] = 1'b1;
        found     = 1'b1;
      end
    end
  end

  // A configured match wins and releases the highest bound match.
  always_comb begin
    if (|cfg_oh) begin
      sel_oh     = cfg_oh;
      release_oh = bnd_oh;
    end else if (|bnd_oh) begin
      sel_oh     = bnd_oh;
      release_oh = '0;
    end else begin
      sel_oh     = unb_oh;
      release_oh = '0;
    end
  end

  // Encode the chosen slot; only the low four slots can ever be chosen.
  always_comb begin
    sel_idx = 2'd0;
    for (int i = 0; i < SLOTS; i++) begin
      if (sel_oh[i]) begin
        sel_idx = sel_idx | 2'(i);
      end
    end
  end

endmodule

### rtl/rmsr_slot_store.sv
module rmsr_slot_store #(
  parameter int SLOTS = rmsr_pkg::NUM_SLOTS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  rmsr_pkg::cfg_t      cfg,
  input  rmsr_pkg::item_t     item,
  input  logic [SLOTS-1:0]    sel_oh,
  input  logic [SLOTS-1:0]    release_oh,
  input  logic [1:0]          sel_idx,
  output logic [SLOTS-1:0]    bound_valid,
  output logic [1:0]          bound_bus [SLOTS],
  output logic [6:0]          bound_node [SLOTS],
  output rmsr_pkg::result_t   result
);
  import rmsr_pkg::*;

  logic [15:0] pending_range     [SLOTS];
  logic [31:0] last_reading_time [SLOTS];
  logic [1:0]  pending_status    [SLOTS];
  logic [SLOTS-1:0] fresh_flag;
  logic [1:0]  reported_status   [SLOTS];
  logic [15:0] reported_range    [SLOTS];
  logic [1:0]  kind_store        [SLOTS];

  logic [SLOTS-1:0] poll_oh;
  logic [SLOTS-1:0] read_oh;
  logic [15:0] rd_prange;
  logic [31:0] rd_time;
  logic [1:0]  rd_pstatus;
  logic        rd_fresh;
  logic [1:0]  rd_rstatus;
  logic [15:0] rd_rrange;
  logic [1:0]  rd_kind;
  logic [31:0] age;
  logic        stale;
  logic        reading;
  logic [1:0]  new_kind;
  logic        msg_fire;
  logic        poll_fire;

  // Poll decode; a poll past the last slot selects nothing.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      poll_oh[i] = (32'(item.poll_slot) == 32'(i));
    end
  end

  assign read_oh = item.mode ? poll_oh : sel_oh;

  // One-hot read of the addressed slot.
  always_comb begin
    rd_prange  = '0;
    rd_time    = '0;
    rd_pstatus = '0;
    rd_fresh   = 1'b0;
    rd_rstatus = '0;
    rd_rrange  = '0;
    rd_kind    = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (read_oh[i]) begin
        rd_prange  = rd_prange  | pending_range[i];
        rd_time    = rd_time    | last_reading_time[i];
        rd_pstatus = rd_pstatus | pending_status[i];
        rd_fresh   = rd_fresh   | fresh_flag[i];
        rd_rstatus = rd_rstatus | reported_status[i];
        rd_rrange  = rd_rrange  | reported_range[i];
        rd_kind    = rd_kind    | kind_store[i];
      end
    end
  end

  // Age check wraps with the millisecond counter.
  assign age      = item.now_ms - rd_time;
  assign stale    = age > {16'd0, cfg.stale_timeout_ms};
  assign reading  = is_reading(item.reading_kind);
  assign new_kind = map_kind(item.sensor_kind_in);

  assign msg_fire  = fire && !item.mode;
  assign poll_fire = fire && item.mode;

  // Result of the item, all zero when nothing matched.
  always_comb begin
    result = '0;
    if (item.mode) begin
      if (|poll_oh) begin
        result.matched   = 1'b1;
        result.slot_index = item.poll_slot;
        result.sensor_kind = rd_kind;
        if (stale) begin
          result.slot_status = STATUS_NO_DATA;
          result.distance_mm = rd_rrange;
        end else if (rd_fresh) begin
          result.slot_status = rd_pstatus;
          result.distance_mm = rd_prange;
        end else begin
          result.slot_status = rd_rstatus;
          result.distance_mm = rd_rrange;
        end
      end
    end else if (|sel_oh) begin
      result.matched     = 1'b1;
      result.slot_index  = sel_idx;
      result.sensor_kind = new_kind;
      result.slot_status = reading ? item.reading_kind[1:0] : rd_pstatus;
      result.distance_mm = reading ? item.range_mm : rd_prange;
    end
  end

  // Per-slot state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      bound_valid <= '0;
      fresh_flag  <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        bound_bus[i]         <= '0;
        bound_node[i]        <= '0;
        pending_range[i]     <= '0;
        last_reading_time[i] <= '0;
        pending_status[i]    <= '0;
        reported_status[i]   <= STATUS_NO_DATA;
        reported_range[i]    <= '0;
        kind_store[i]        <= '0;
      end
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (msg_fire && release_oh[i]) begin
          bound_valid[i] <= 1'b0;
        end
        if (msg_fire && sel_oh[i]) begin
          bound_valid[i] <= 1'b1;
          bound_bus[i]   <= item.can_bus;
          bound_node[i]  <= item.source_node;
          kind_store[i]  <= new_kind;
          if (reading) begin
            pending_range[i]     <= item.range_mm;
            last_reading_time[i] <= item.now_ms;
            pending_status[i]    <= item.reading_kind[1:0];
            fresh_flag[i]        <= 1'b1;
          end
        end
        if (poll_fire && poll_oh[i]) begin
          if (stale) begin
            reported_status[i] <= STATUS_NO_DATA;
          end else if (fresh_flag[i]) begin
            reported_range[i]  <= pending_range[i];
            reported_status[i] <= pending_status[i];
            fresh_flag[i]      <= 1'b0;
          end
        end
      end
    end
  end

endmodule

### rtl/range_message_slot_router_unit.sv
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  s_tuser = mode, s_tdata = message or poll fields
// m_*       out        m_tvalid / m_tready  m_tuser = matched, m_tdata = slot result
// cfg_*     in         cfg_valid/cfg_ready  cfg_index = register, cfg_data = value
//
// One transaction per cycle while m_tready holds; an item waits in the input register
// until the output stage can advance, then its result is offered from the output register.
// Throughput is set by the single pass from the input register through the slot
// match and the slot state update into the output register.
// rst is synchronous: it clears all slot state and loads the timeout with 500 ms.
// A stalled output holds its result and the input register; s_tready falls only
// while both stages are full.
module range_message_slot_router_unit #(
  parameter int SLOTS = rmsr_pkg::NUM_SLOTS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // can_bus[1:0], source_node[8:2], target_id[16:9], reading_kind[24:17],
  // sensor_kind_in[32:25], range_mm[48:33], poll_slot[50:49], now_ms[82:51]
  input  logic [rmsr_pkg::IN_TDATA_W-1:0]       s_tdata,
  // mode[0]
  input  logic                                  s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // slot_index[1:0], slot_status[3:2], distance_mm[19:4], sensor_kind[21:20]
  output logic [rmsr_pkg::OUT_TDATA_W-1:0]      m_tdata,
  // matched[0]
  output logic                                  m_tuser,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [rmsr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rmsr_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import rmsr_pkg::*;

  cfg_t        cfg;
  item_t       in_item;
  logic        in_valid;
  result_t     out_res;
  logic        out_valid;
  result_t     result;
  logic        advance;
  logic        fire;
  logic        s_fire;

  logic [SLOTS-1:0] bound_valid;
  logic [1:0]       bound_bus [SLOTS];
  logic [6:0]       bound_node [SLOTS];
  logic [SLOTS-1:0] sel_oh;
  logic [SLOTS-1:0] release_oh;
  logic [1:0]       sel_idx;

  rmsr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Handshake between the two register stages.
  assign advance  = !out_valid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;
  assign s_fire   = s_tvalid && s_tready;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_fire) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_item.mode           <= s_tuser;
      in_item.can_bus        <= s_tdata[1:0];
      in_item.source_node    <= s_tdata[8:2];
      in_item.target_id      <= s_tdata[16:9];
      in_item.reading_kind   <= s_tdata[24:17];
      in_item.sensor_kind_in <= s_tdata[32:25];
      in_item.range_mm       <= s_tdata[48:33];
      in_item.poll_slot      <= s_tdata[50:49];
      in_item.now_ms         <= s_tdata[82:51];
    end
  end

  rmsr_slot_match #(.SLOTS(SLOTS)) u_match (
    .cfg         (cfg),
    .item        (in_item),
    .bound_valid (bound_valid),
    .bound_bus   (bound_bus),
    .bound_node  (bound_node),
    .sel_oh      (sel_oh),
    .release_oh  (release_oh),
    .sel_idx     (sel_idx)
  );

  rmsr_slot_store #(.SLOTS(SLOTS)) u_store (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .cfg         (cfg),
    .item        (in_item),
    .sel_oh      (sel_oh),
    .release_oh  (release_oh),
    .sel_idx     (sel_idx),
    .bound_valid (bound_valid),
    .bound_bus   (bound_bus),
    .bound_node  (bound_node),
    .result      (result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.matched;
  assign m_tdata  = {2'b00, out_res.sensor_kind, out_res.distance_mm,
                     out_res.slot_status, out_res.slot_index};

  // A result with no matching slot carries all-zero fields.
  a_unmatched_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("unmatched result carries nonzero fields");

  // The input side only stalls while a full output stage is held.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && out_valid && !m_tready))
    else $error("input stalled without an output stall");

  // Reset loads the default stale timeout.
  a_reset_timeout: assert property (@(posedge clk)
    rst |=> (cfg.stale_timeout_ms == STALE_RESET))
    else $error("stale timeout not at its reset value");

  // An item that fires from the input register always reaches the output stage.
  a_fire_loads: assert property (@(posedge clk) disable iff (rst)
    fire |=> m_tvalid)
    else $error("processed item did not reach the output stage");

endmodule

### tb/testbench.sv
module testbench;
  import rmsr_pkg::*;

  localparam int NSLOT = NUM_SLOTS;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_ITEMS = 118;
  localparam int HOLD_PHASE = 3;
  localparam int DRAIN_PHASE = 5;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_SLACK = 4;

  // Codes that the package does not name.
  localparam logic MODE_MSG = 1'b0;
  localparam logic MODE_POLL = 1'b1;
  localparam logic [7:0] KIND_IN_LIDAR = 8'd2;
  localparam logic [1:0] KIND_UNKNOWN = 2'd0;

  typedef enum logic {ROW_SETTING, ROW_ITEM} row_kind_t;

  // One offered item, with an expectation typed in by hand where pinned is set.
  typedef struct {
    item_t   it;
    bit      pinned;
    result_t want;
  } offer_t;

  typedef struct {
    row_kind_t kind;
    cfg_t      setting;
    offer_t    entry;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata;
  logic s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic m_tuser;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  range_message_slot_router_unit dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Register copy used by the router prediction.
  logic [3:0]  p_en = '0;
  logic [31:0] p_addr = '0;
  logic [27:0] p_recv = '0;
  logic [15:0] p_timeout = STALE_RESET;

  // Per-slot binding and reading state.
  logic [NSLOT-1:0]       bnd_valid = '0;
  logic [NSLOT-1:0][1:0]  bnd_bus = '0;
  logic [NSLOT-1:0][6:0]  bnd_node = '0;
  logic [NSLOT-1:0][15:0] pend_range = '0;
  logic [NSLOT-1:0][31:0] pend_time = '0;
  logic [NSLOT-1:0][1:0]  pend_status = '0;
  logic [NSLOT-1:0]       fresh = '0;
  logic [NSLOT-1:0][1:0]  shown_status = '0;
  logic [NSLOT-1:0][15:0] shown_range = '0;
  logic [NSLOT-1:0][1:0]  held_kind = '0;

  offer_t    sent_items_q[$];
  result_t   slot_reports_q[$];
  stim_row_t stim_q[$];

  logic [7:0] id_pool [3];
  logic [6:0] node_pool [3];
  logic [31:0] clock_ms = 32'd5000;

  bit idling = 1'b0;
  bit hold_request = 1'b0;
  int n_errors = 0;
  int n_results = 0;
  int n_msgs = 0;
  int n_routed = 0;
  int n_polls = 0;
  int n_settings = 0;
  int cycles = 0;

  result_t seen;
  result_t owed;
  result_t guess;
  offer_t  took;

  // Free-running clock, period 2.
  initial begin
    forever #1 clk = ~clk;
  end

  // Cycle budget for the whole run.
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
        $display("run stopped at the cycle limit with %0d results outstanding",
                 slot_reports_q.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic flag_mismatch(input string msg);
    n_errors++;
    $display("mismatch: %s", msg);
  endtask

  task automatic apply_reg(input cfg_reg_t idx, input logic [31:0] val);
    case (idx)
      REG_SLOT_ENABLE: begin
        p_en = val[3:0];
      end
      REG_SLOT_SENSOR_ADDR: begin
        p_addr = val;
      end
      REG_SLOT_RECV_NODE: begin
        p_recv = val[27:0];
      end
      REG_STALE_TIMEOUT: begin
        p_timeout = val[15:0];
      end
      default: begin
      end
    endcase
  endtask

  // Predicts the result of one item and updates the slot state.
  function automatic result_t route_item(input item_t it);
    result_t r;
    logic [1:0] ps;
    logic [31:0] age;
    logic [6:0] rv;
    int cfg_hit;
    int bnd_hit;
    int free_hit;
    int pick;
    r = '0;
    ps = it.poll_slot;
    // A poll refreshes the reported status from the pending reading or ages it out.
    if (it.mode == MODE_POLL) begin
      age = it.now_ms - pend_time[ps];
      if (age > {16'd0, p_timeout}) begin
        shown_status[ps] = STATUS_NO_DATA;
      end else if (fresh[ps]) begin
        shown_range[ps] = pend_range[ps];
        shown_status[ps] = pend_status[ps];
        fresh[ps] = 1'b0;
      end
      r.matched = 1'b1;
      r.slot_index = ps;
      r.slot_status = shown_status[ps];
      r.distance_mm = shown_range[ps];
      r.sensor_kind = held_kind[ps];
      return r;
    end
    // Classify every candidate slot for the message.
    cfg_hit = -1;
    bnd_hit = -1;
    free_hit = -1;
    for (int i = 0; i < NSLOT; i++) begin
      if (p_en[i] && p_addr[8*i +: 8] == it.target_id) begin
        rv = p_recv[7*i +: 7];
        if (rv != 7'd0) begin
          if (rv == it.source_node && cfg_hit < 0) begin
            cfg_hit = i;
          end
        end else if (!bnd_valid[i]) begin
          if (free_hit < 0) begin
            free_hit = i;
          end
        end else if (bnd_bus[i] == it.can_bus && bnd_node[i] == it.source_node) begin
          bnd_hit = i;
        end
      end
    end
    // A configured slot wins over a bound one and releases its binding.
    if (cfg_hit >= 0 && bnd_hit >= 0) begin
      bnd_valid[bnd_hit] = 1'b0;
      bnd_hit = -1;
    end
    pick = (cfg_hit >= 0) ? cfg_hit : ((bnd_hit >= 0) ? bnd_hit : free_hit);
    if (pick < 0) begin
      return r;
    end
    bnd_valid[pick] = 1'b1;
    bnd_bus[pick] = it.can_bus;
    bnd_node[pick] = it.source_node;
    if (it.reading_kind >= READ_VALID && it.reading_kind <= READ_TOO_FAR) begin
      pend_range[pick] = it.range_mm;
      pend_time[pick] = it.now_ms;
      pend_status[pick] = it.reading_kind[1:0];
      fresh[pick] = 1'b1;
    end
    if (it.sensor_kind_in >= KIND_IN_SONAR && it.sensor_kind_in <= KIND_IN_RADAR) begin
      held_kind[pick] = it.sensor_kind_in[1:0];
    end else begin
      held_kind[pick] = KIND_UNKNOWN;
    end
    r.matched = 1'b1;
    r.slot_index = pick[1:0];
    r.slot_status = pend_status[pick];
    r.distance_mm = pend_range[pick];
    r.sensor_kind = held_kind[pick];
    return r;
  endfunction

  // Monitor: checks results, then records accepted inputs and register writes.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        n_results++;
        seen.matched = m_tuser;
        seen.slot_index = m_tdata[1:0];
        seen.slot_status = m_tdata[3:2];
        seen.distance_mm = m_tdata[19:4];
        seen.sensor_kind = m_tdata[21:20];
        if (slot_reports_q.size() == 0) begin
          flag_mismatch($sformatf("result %0d arrived with none outstanding", n_results));
        end else begin
          owed = slot_reports_q.pop_front();
          if (seen.matched !== owed.matched) begin
            flag_mismatch($sformatf("result %0d matched: got %0b, expected %0b",
                                    n_results, seen.matched, owed.matched));
          end
          if (seen.slot_index !== owed.slot_index) begin
            flag_mismatch($sformatf("result %0d slot_index: got %0d, expected %0d",
                                    n_results, seen.slot_index, owed.slot_index));
          end
          if (seen.slot_status !== owed.slot_status) begin
            flag_mismatch($sformatf("result %0d slot_status: got %0d, expected %0d",
                                    n_results, seen.slot_status, owed.slot_status));
          end
          if (seen.distance_mm !== owed.distance_mm) begin
            flag_mismatch($sformatf("result %0d distance_mm: got %0d, expected %0d",
                                    n_results, seen.distance_mm, owed.distance_mm));
          end
          if (seen.sensor_kind !== owed.sensor_kind) begin
            flag_mismatch($sformatf("result %0d sensor_kind: got %0d, expected %0d",
                                    n_results, seen.sensor_kind, owed.sensor_kind));
          end
        end
      end
      if (s_tvalid && s_tready) begin
        took = sent_items_q.pop_front();
        guess = route_item(took.it);
        slot_reports_q.push_back(took.pinned ? took.want : guess);
        if (took.it.mode == MODE_POLL) begin
          n_polls++;
        end else begin
          n_msgs++;
          if (guess.matched) begin
            n_routed++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        apply_reg(cfg_reg_t'(cfg_index), cfg_data);
      end
    end
  end

  // Output side: random stall bursts, and one long hold-off on request.
  initial begin
    m_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
        m_tready = 1'b1;
      end else if (idling && $urandom_range(0, 7) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        m_tready = 1'b1;
      end
    end
  end

  // Stops offering and waits until every outstanding result has come back.
  task automatic drain();
    s_tvalid = 1'b0;
    while (slot_reports_q.size() != 0) @(negedge clk);
    repeat (DRAIN_SLACK) @(negedge clk);
  endtask

  // Writes all four registers while the block is idle; unused upper bits carry junk.
  task automatic program_regs(input cfg_t c);
    cfg_reg_t idx [4];
    logic [31:0] val [4];
    logic [31:0] junk;
    drain();
    junk = $urandom;
    idx[0] = REG_SLOT_ENABLE;
    idx[1] = REG_SLOT_SENSOR_ADDR;
    idx[2] = REG_SLOT_RECV_NODE;
    idx[3] = REG_STALE_TIMEOUT;
    val[0] = {junk[31:4], c.slot_enable};
    val[1] = c.slot_sensor_addr;
    val[2] = {junk[31:28], c.slot_recv_node};
    val[3] = {junk[31:16], c.stale_timeout_ms};
    for (int k = 0; k < 4; k++) begin
      cfg_valid = 1'b1;
      cfg_index = idx[k];
      cfg_data = val[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid = 1'b0;
    n_settings++;
  endtask

  // Offers one item, after an optional gap, and returns once it is accepted.
  task automatic offer(input offer_t e);
    if (idling && $urandom_range(0, 5) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    sent_items_q.push_back(e);
    s_tvalid = 1'b1;
    s_tuser = e.it.mode;
    s_tdata = {5'd0, e.it.now_ms, e.it.poll_slot, e.it.range_mm, e.it.sensor_kind_in,
               e.it.reading_kind, e.it.target_id, e.it.source_node, e.it.can_bus};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic item_t msg(input logic [1:0] bus, input logic [6:0] node,
                                input logic [7:0] sid, input logic [7:0] rk,
                                input logic [7:0] sk, input logic [15:0] range_v,
                                input logic [31:0] now);
    item_t it;
    it = '0;
    it.mode = MODE_MSG;
    it.can_bus = bus;
    it.source_node = node;
    it.target_id = sid;
    it.reading_kind = rk;
    it.sensor_kind_in = sk;
    it.range_mm = range_v;
    it.now_ms = now;
    return it;
  endfunction

  function automatic item_t poll(input logic [1:0] ps, input logic [31:0] now);
    item_t it;
    it = '0;
    it.mode = MODE_POLL;
    it.poll_slot = ps;
    it.now_ms = now;
    return it;
  endfunction

  task automatic add_setting(input logic [3:0] en, input logic [31:0] addr,
                             input logic [27:0] recv, input logic [15:0] tmo);
    stim_row_t row;
    row = '{kind: ROW_SETTING, setting: '0, entry: '{it: '0, pinned: 1'b0, want: '0}};
    row.setting.slot_enable = en;
    row.setting.slot_sensor_addr = addr;
    row.setting.slot_recv_node = recv;
    row.setting.stale_timeout_ms = tmo;
    stim_q.push_back(row);
  endtask

  task automatic add_item(input item_t it, input bit pinned, input result_t want);
    stim_row_t row;
    row = '{kind: ROW_ITEM, setting: '0, entry: '{it: it, pinned: pinned, want: want}};
    stim_q.push_back(row);
  endtask

  // Random register setting drawn from the sensor id and node pools of the phase.
  function automatic cfg_t rand_setting(input int ph);
    cfg_t c;
    int pick;
    c = '0;
    c.slot_enable = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'hF;
    for (int i = 0; i < NSLOT; i++) begin
      c.slot_sensor_addr[8*i +: 8] = id_pool[$urandom_range(0, 2)];
      if ($urandom_range(0, 1) == 0) begin
        c.slot_recv_node[7*i +: 7] = 7'd0;
      end else begin
        c.slot_recv_node[7*i +: 7] = node_pool[$urandom_range(0, 2)];
      end
    end
    pick = $urandom_range(0, 5);
    case (pick)
      0: c.stale_timeout_ms = 16'd1;
      1: c.stale_timeout_ms = 16'hFFFF;
      4: c.stale_timeout_ms = 16'($urandom_range(1, 65535));
      5: c.stale_timeout_ms = 16'($urandom_range(20, 120));
      default: c.stale_timeout_ms = 16'($urandom_range(1, 400));
    endcase
    // Two phases pin the timeout to its extremes with every slot on.
    if (ph == 1) begin
      c.slot_enable = 4'hF;
      c.stale_timeout_ms = 16'd1;
    end else if (ph == 2) begin
      c.slot_enable = 4'hF;
      c.stale_timeout_ms = 16'hFFFF;
    end
    return c;
  endfunction

  // Random item, mostly aimed at the configured ids and nodes, with some noise.
  function automatic item_t rand_item();
    item_t it;
    int pick;
    it.mode = ($urandom_range(0, 9) < 3) ? MODE_POLL : MODE_MSG;
    it.can_bus = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) :
                                               2'($urandom_range(0, 1));
    it.source_node = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127)) :
                                                   node_pool[$urandom_range(0, 2)];
    it.target_id = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) :
                                                 id_pool[$urandom_range(0, 2)];
    it.reading_kind = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) :
                                                    8'($urandom_range(0, 4));
    it.sensor_kind_in = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) :
                                                      8'($urandom_range(0, 4));
    pick = $urandom_range(0, 9);
    it.range_mm = (pick == 0) ? 16'hFFFF : ((pick == 1) ? 16'd0 :
                                            16'($urandom_range(0, 65535)));
    it.poll_slot = 2'($urandom_range(0, 3));
    // Time mostly creeps forward, sometimes jumps, and now and then lands anywhere.
    pick = $urandom_range(0, 99);
    if (pick == 0) begin
      clock_ms = $urandom;
    end else if (pick < 4) begin
      clock_ms = clock_ms + 32'($urandom_range(0, 70000));
    end else begin
      clock_ms = clock_ms + 32'($urandom_range(0, 60));
    end
    it.now_ms = clock_ms;
    return it;
  endfunction

  // Stimulus: reset, the directed table, then random phases.
  initial begin
    offer_t e;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_SLOT_ENABLE;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset state: nothing routes, polls report no data.
    add_item(msg(2'd3, 7'd127, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF), 1'b1, '0);
    add_item(poll(2'd0, 32'd0), 1'b1,
             '{matched: 1'b1, slot_index: 2'd0, slot_status: STATUS_NO_DATA,
               distance_mm: 16'd0, sensor_kind: KIND_UNKNOWN});
    add_item(poll(2'd3, 32'hFFFF_FFFF), 1'b1,
             '{matched: 1'b1, slot_index: 2'd3, slot_status: STATUS_NO_DATA,
               distance_mm: 16'd0, sensor_kind: KIND_UNKNOWN});
    // All slots on one id, any node: binding, rebinding and the reading kinds.
    add_setting(4'hF, 32'h1010_1010, 28'd0, 16'd100);
    add_item(msg(2'd0, 7'd5, 8'h10, READ_VALID, KIND_IN_SONAR, 16'd0, 32'd1000), 1'b0, '0);
    add_item(msg(2'd0, 7'd5, 8'h10, READ_TOO_CLOSE, KIND_IN_LIDAR, 16'd50, 32'd1010),
             1'b0, '0);
    add_item(msg(2'd3, 7'd127, 8'h10, READ_TOO_FAR, KIND_IN_RADAR, 16'hFFFF, 32'd1020),
             1'b0, '0);
    add_item(msg(2'd0, 7'd5, 8'h10, 8'd0, 8'd200, 16'd4321, 32'd1030), 1'b0, '0);
    add_item(msg(2'd1, 7'd5, 8'h11, READ_VALID, KIND_IN_SONAR, 16'd5, 32'd1040), 1'b1, '0);
    // Fresh copy, age exactly at the timeout, then one past it.
    add_item(poll(2'd0, 32'd1050), 1'b0, '0);
    add_item(poll(2'd0, 32'd1110), 1'b0, '0);
    add_item(poll(2'd0, 32'd1111), 1'b0, '0);
    // With slot 0 off the same sender binds a second slot, so two are bound.
    add_setting(4'hE, 32'h1010_1010, 28'd0, 16'd100);
    add_item(msg(2'd0, 7'd5, 8'h10, READ_VALID, KIND_IN_RADAR, 16'd777, 32'd2000), 1'b0, '0);
    add_setting(4'hF, 32'h1010_1010, 28'd0, 16'd100);
    add_item(msg(2'd0, 7'd5, 8'h10, READ_VALID, KIND_IN_SONAR, 16'd888, 32'd2100), 1'b0, '0);
    // A configured slot next to bound ones releases them one at a time.
    add_setting(4'hF, 32'h1010_1010, 28'd5 << 21, 16'd100);
    add_item(msg(2'd0, 7'd5, 8'h10, READ_TOO_FAR, KIND_IN_LIDAR, 16'd999, 32'd2200),
             1'b0, '0);
    add_item(msg(2'd0, 7'd5, 8'h10, READ_VALID, KIND_IN_LIDAR, 16'd1000, 32'd2300),
             1'b0, '0);
    add_item(msg(2'd2, 7'd9, 8'h10, READ_VALID, 8'd255, 16'd2000, 32'd2400), 1'b0, '0);
    // Disabled slots still answer polls but take no messages.
    add_setting(4'h0, 32'h1010_1010, 28'd5 << 21, 16'd100);
    add_item(poll(2'd2, 32'd2400), 1'b0, '0);
    add_item(msg(2'd2, 7'd9, 8'h10, READ_VALID, KIND_IN_SONAR, 16'd1, 32'd2401), 1'b1, '0);
    // Extreme ids and node, longest timeout, time wrapping through zero.
    add_setting(4'hF, 32'h00FF_00FF, 28'h7F, 16'hFFFF);
    add_item(msg(2'd1, 7'd127, 8'hFF, READ_VALID, KIND_IN_RADAR, 16'hFFFF, 32'hFFFF_FFF0),
             1'b0, '0);
    add_item(poll(2'd0, 32'h10), 1'b0, '0);
    add_item(msg(2'd0, 7'd0, 8'h00, READ_TOO_CLOSE, KIND_IN_SONAR, 16'd1, 32'h20), 1'b0, '0);
    add_setting(4'hF, 32'h00FF_00FF, 28'h7F, 16'd1);
    add_item(poll(2'd3, 32'h20), 1'b0, '0);

    idling = 1'b1;
    foreach (stim_q[k]) begin
      if (stim_q[k].kind == ROW_SETTING) begin
        program_regs(stim_q[k].setting);
      end else begin
        offer(stim_q[k].entry);
      end
    end

    // Random phases, each under a fresh register setting.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      id_pool[0] = 8'($urandom_range(0, 255));
      id_pool[1] = (ph % 2 == 0) ? 8'h00 : 8'hFF;
      id_pool[2] = 8'($urandom_range(0, 255));
      node_pool[0] = 7'($urandom_range(1, 127));
      node_pool[1] = 7'd127;
      node_pool[2] = 7'($urandom_range(0, 127));
      if (ph == 4) begin
        clock_ms = 32'hFFFF_FF00;
      end
      program_regs(rand_setting(ph));
      if (ph == HOLD_PHASE) begin
        hold_request = 1'b1;
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        idling = (ph < NUM_PHASES - 1) && (k < PHASE_ITEMS * 3 / 4);
        if (ph == DRAIN_PHASE && k == PHASE_ITEMS / 2) begin
          drain();
        end
        e.it = rand_item();
        e.pinned = 1'b0;
        e.want = '0;
        offer(e);
      end
    end

    idling = 1'b0;
    drain();
    repeat (8) @(negedge clk);
    $display("covered %0d items: %0d messages (%0d routed to a slot), %0d polls",
             n_msgs + n_polls, n_msgs, n_routed, n_polls);
    $display("across %0d register settings with a long output stall and drain pauses; %0d %s",
             n_settings, n_results, $sformatf("results checked, %0d mismatches", n_errors));
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/rmsr_pkg.sv
rtl/rmsr_cfg_regs.sv
rtl/rmsr_slot_match.sv
rtl/rmsr_slot_store.sv
rtl/range_message_slot_router_unit.sv
tb/testbench.sv
